@@ rtl/core/qts_pkg.sv @@
// shared types, constants and helpers for the quoted token splitter
package qts_pkg;

   localparam int MAX_SEPARATORS = 4;
   localparam int SEP_SLOTS      = 4;
   localparam int SEP_LIMIT      = (MAX_SEPARATORS < SEP_SLOTS) ? MAX_SEPARATORS : SEP_SLOTS;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

   localparam logic [7:0] CHAR_SQUOTE = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;

   localparam logic [2:0] REG_SEP_BYTES = 3'd0;
   localparam logic [2:0] REG_SEP_COUNT = 3'd1;
   localparam logic [2:0] REG_MAX_TOKENS = 3'd2;
   localparam logic [2:0] REG_TRIM_RUNS = 3'd3;
   localparam logic [2:0] REG_ALLOW_QUOTES = 3'd4;

   typedef enum logic [2:0] {
      MODE_START  = 3'd0,
      MODE_PLAIN  = 3'd1,
      MODE_QUOTED = 3'd2,
      MODE_ESCAPE = 3'd3,
      MODE_CLOSED = 3'd4
   } mode_type;

   typedef struct packed {
      logic [31:0] separator_bytes;
      logic [2:0]  separator_count;
      logic [7:0]  max_tokens;
      logic        trim_runs;
      logic        allow_quotes;
   } cfg_type;

   // classified request as it travels through the queue
   typedef struct packed {
      logic [7:0] in_byte;
      logic [7:0] esc_byte;
      logic       end_of_string;
      logic       is_sep;
      logic       is_squote;
      logic       is_dquote;
      logic       is_bslash;
   } entry_type;

   function automatic logic [7:0] unescape(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b == CHAR_N) r = CHAR_LF;
      else if (b == CHAR_R) r = CHAR_CR;
      else if (b == CHAR_T) r = CHAR_TAB;
      return r;
   endfunction

endpackage

@@ rtl/core/qts_front.sv @@
// front stage: takes requests and classifies each byte
module qts_front #(
   parameter int MAX_SEPARATORS = qts_pkg::MAX_SEPARATORS
) (
   input  logic                clock,
   input  logic                reset,
   input  qts_pkg::cfg_type    cfg,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_in_byte,
   input  logic                req_end_of_string,
   output logic                q_wr_valid,
   input  logic                q_wr_ready,
   output qts_pkg::entry_type  q_wr_data
);

   localparam int SEP_LIMIT = (MAX_SEPARATORS < qts_pkg::SEP_SLOTS) ? MAX_SEPARATORS
                                                                    : qts_pkg::SEP_SLOTS;

   logic               fr_valid_ff, fr_valid_in;
   qts_pkg::entry_type entry_ff, entry_in;
   logic [2:0]         sep_n;
   logic               sep_hit;
   logic               take;

   assign req_ready  = !fr_valid_ff || q_wr_ready;
   assign take       = req_valid && req_ready;
   assign q_wr_valid = fr_valid_ff;
   assign q_wr_data  = entry_ff;

   // active separator slots, clamped
   assign sep_n = (cfg.separator_count > 3'(SEP_LIMIT)) ?
                  3'(SEP_LIMIT) : cfg.separator_count;

   always_comb begin
      sep_hit = 1'b0;
      for (int i = 0; i < qts_pkg::SEP_SLOTS; i++) begin
         if ((3'(i) < sep_n) && (cfg.separator_bytes[8*i +: 8] == req_in_byte))
            sep_hit = 1'b1;
      end
   end

   always_comb begin
      entry_in               = entry_ff;
      if (take) begin
         entry_in.in_byte       = req_in_byte;
         entry_in.esc_byte      = qts_pkg::unescape(req_in_byte);
         entry_in.end_of_string = req_end_of_string;
         entry_in.is_sep        = sep_hit;
         entry_in.is_squote     = (req_in_byte == qts_pkg::CHAR_SQUOTE);
         entry_in.is_dquote     = (req_in_byte == qts_pkg::CHAR_DQUOTE);
         entry_in.is_bslash     = (req_in_byte == qts_pkg::CHAR_BSLASH);
      end
   end

   always_comb begin
      fr_valid_in = fr_valid_ff;
      if (take) fr_valid_in = 1'b1;
      else if (q_wr_ready) fr_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
      entry_ff <= entry_in;
   end

endmodule

@@ rtl/core/qts_queue.sv @@
// short fifo between the classifier and the token state machine
module qts_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_valid,
   output logic                wr_ready,
   input  qts_pkg::entry_type  wr_data,
   output logic                rd_valid,
   input  logic                rd_ready,
   output qts_pkg::entry_type  rd_data
);

   qts_pkg::entry_type            mem_ff [qts_pkg::QUEUE_DEPTH];
   logic [qts_pkg::QUEUE_AW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [qts_pkg::QUEUE_AW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [qts_pkg::QUEUE_AW:0]    count_ff, count_in;
   logic                          push, pop;

   assign wr_ready = (count_ff != (qts_pkg::QUEUE_AW+1)'(qts_pkg::QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

@@ rtl/core/qts_back.sv @@
// back stage: token state machine and registered response
module qts_back (
   input  logic                clock,
   input  logic                reset,
   input  qts_pkg::cfg_type    cfg,
   input  logic                q_rd_valid,
   output logic                q_rd_ready,
   input  qts_pkg::entry_type  q_rd_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_token_done,
   output logic [7:0]          rsp_token_number,
   output logic                rsp_string_done,
   output logic [7:0]          rsp_tokens_total
);

   qts_pkg::mode_type mode_ff, mode_in;
   logic              quote_dq_ff, quote_dq_in;
   logic [7:0]        tokens_ff, tokens_in, tokens_inc;
   logic              last;
   logic              take;
   logic [7:0]        o_byte;
   logic              o_valid, o_done;
   qts_pkg::entry_type e;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        out_byte_ff, token_number_ff, tokens_total_ff;
   logic              byte_valid_ff, token_done_ff, string_done_ff;

   assign e          = q_rd_data;
   assign q_rd_ready = !rsp_valid_ff || rsp_ready;
   assign take       = q_rd_valid && q_rd_ready;

   assign last       = (cfg.max_tokens != 8'd0) && (tokens_ff >= cfg.max_tokens - 8'd1);
   assign tokens_inc = (tokens_ff != 8'hFF) ? tokens_ff + 8'd1 : tokens_ff;

   // result of the current request
   always_comb begin
      o_byte  = 8'd0;
      o_valid = 1'b0;
      o_done  = 1'b0;
      if (e.end_of_string) begin
         priority if (mode_ff == qts_pkg::MODE_START) o_done = !cfg.trim_runs;
         else if (mode_ff != qts_pkg::MODE_CLOSED) o_done = 1'b1;
         else o_done = 1'b0;
      end else begin
         unique case (mode_ff)
            qts_pkg::MODE_START: begin
               priority if (cfg.trim_runs && e.is_sep) begin
                  o_done = 1'b0;
               end else if (!last && cfg.allow_quotes && (e.is_squote || e.is_dquote)) begin
                  o_done = 1'b0;
               end else if (!last && e.is_sep) begin
                  o_done = 1'b1;
               end else begin
                  o_byte  = e.in_byte;
                  o_valid = 1'b1;
               end
            end
            qts_pkg::MODE_PLAIN: begin
               if (!last && e.is_sep) begin
                  o_done = 1'b1;
               end else begin
                  o_byte  = e.in_byte;
                  o_valid = 1'b1;
               end
            end
            qts_pkg::MODE_QUOTED: begin
               priority if (e.is_bslash) begin
                  o_done = 1'b0;
               end else if (quote_dq_ff ? e.is_dquote : e.is_squote) begin
                  o_done = 1'b1;
               end else begin
                  o_byte  = e.in_byte;
                  o_valid = 1'b1;
               end
            end
            qts_pkg::MODE_ESCAPE: begin
               o_byte  = e.esc_byte;
               o_valid = 1'b1;
            end
            default: begin
               o_done = 1'b0;
            end
         endcase
      end
   end

   // next parser state
   always_comb begin
      mode_in     = mode_ff;
      quote_dq_in = quote_dq_ff;
      tokens_in   = tokens_ff;
      if (take) begin
         if (e.end_of_string) begin
            mode_in     = qts_pkg::MODE_START;
            quote_dq_in = 1'b0;
            tokens_in   = 8'd0;
         end else begin
            tokens_in = o_done ? tokens_inc : tokens_ff;
            unique case (mode_ff)
               qts_pkg::MODE_START: begin
                  priority if (cfg.trim_runs && e.is_sep) begin
                     mode_in = qts_pkg::MODE_START;
                  end else if (!last && cfg.allow_quotes && (e.is_squote || e.is_dquote)) begin
                     quote_dq_in = e.is_dquote;
                     mode_in     = qts_pkg::MODE_QUOTED;
                  end else if (!last && e.is_sep) begin
                     mode_in = qts_pkg::MODE_START;
                  end else begin
                     mode_in = qts_pkg::MODE_PLAIN;
                  end
               end
               qts_pkg::MODE_PLAIN: begin
                  mode_in = (!last && e.is_sep) ? qts_pkg::MODE_START : qts_pkg::MODE_PLAIN;
               end
               qts_pkg::MODE_QUOTED: begin
                  priority if (e.is_bslash) mode_in = qts_pkg::MODE_ESCAPE;
                  else if (quote_dq_ff ? e.is_dquote : e.is_squote)
                     mode_in = qts_pkg::MODE_CLOSED;
                  else mode_in = qts_pkg::MODE_QUOTED;
               end
               qts_pkg::MODE_ESCAPE: begin
                  mode_in = qts_pkg::MODE_QUOTED;
               end
               default: begin
                  // byte after a closing quote is dropped
                  mode_in = qts_pkg::MODE_START;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= qts_pkg::MODE_START;
         quote_dq_ff  <= 1'b0;
         tokens_ff    <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         quote_dq_ff  <= quote_dq_in;
         tokens_ff    <= tokens_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take) begin
         out_byte_ff     <= o_byte;
         byte_valid_ff   <= o_valid;
         token_done_ff   <= o_done;
         token_number_ff <= tokens_ff;
         string_done_ff  <= e.end_of_string;
         tokens_total_ff <= o_done ? tokens_inc : tokens_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_byte_valid   = byte_valid_ff;
   assign rsp_token_done   = token_done_ff;
   assign rsp_token_number = token_number_ff;
   assign rsp_string_done  = string_done_ff;
   assign rsp_tokens_total = tokens_total_ff;

endmodule

@@ rtl/core/quoted_token_splitter_top.sv @@
// top level of the quoted token splitter: config registers and the stage chain
//
// usage:
// - req channel: one string byte per request (req_in_byte), or an end request
//   (req_end_of_string high) that closes the string and carries no byte
// - rsp channel: exactly one response per request, in order, with the token
//   byte (if any), the token-done mark, token number and running token total
// - csr channel: register index and data; always ready, write only while idle
//   (0 separator bytes, 1 separator count, 2 max tokens, 3 trim, 4 quotes)
// throughput: one request per cycle, sustained, when rsp_ready stays high
// path: an accepted request reaches rsp_valid through the classifier register,
//   then the 4-entry queue, then the response register
// stalls: when rsp_ready is low the response register holds, the queue fills,
//   and req_ready drops only once the queue and classifier register are full
// reset: synchronous; clears the parser to token start, the token count,
//   the queue and all valids; config returns to its defaults
// (space separator, one separator, no limit, trim on, quotes off)
module quoted_token_splitter_top #(
   parameter int MAX_SEPARATORS = qts_pkg::MAX_SEPARATORS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   input  logic        req_end_of_string,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_token_done,
   output logic [7:0]  rsp_token_number,
   output logic        rsp_string_done,
   output logic [7:0]  rsp_tokens_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   qts_pkg::cfg_type   cfg_ff, cfg_in;
   logic               q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
   qts_pkg::entry_type q_wr_data, q_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            qts_pkg::REG_SEP_BYTES:    cfg_in.separator_bytes = csr_data;
            qts_pkg::REG_SEP_COUNT:    cfg_in.separator_count = csr_data[2:0];
            qts_pkg::REG_MAX_TOKENS:   cfg_in.max_tokens      = csr_data[7:0];
            qts_pkg::REG_TRIM_RUNS:    cfg_in.trim_runs       = csr_data[0];
            qts_pkg::REG_ALLOW_QUOTES: cfg_in.allow_quotes    = csr_data[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.separator_bytes <= 32'd32;
         cfg_ff.separator_count <= 3'd1;
         cfg_ff.max_tokens      <= 8'd0;
         cfg_ff.trim_runs       <= 1'b1;
         cfg_ff.allow_quotes    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   qts_front #(
      .MAX_SEPARATORS (MAX_SEPARATORS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .q_wr_valid        (q_wr_valid),
      .q_wr_ready        (q_wr_ready),
      .q_wr_data         (q_wr_data)
   );

   qts_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (q_wr_valid),
      .wr_ready (q_wr_ready),
      .wr_data  (q_wr_data),
      .rd_valid (q_rd_valid),
      .rd_ready (q_rd_ready),
      .rd_data  (q_rd_data)
   );

   qts_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .q_rd_valid       (q_rd_valid),
      .q_rd_ready       (q_rd_ready),
      .q_rd_data        (q_rd_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_token_done   (rsp_token_done),
      .rsp_token_number (rsp_token_number),
      .rsp_string_done  (rsp_string_done),
      .rsp_tokens_total (rsp_tokens_total)
   );

endmodule
